@@ rtl/core/adc_avg_pkg.sv @@
// Shared types and constants for the four-channel ADC averager.
package adc_avg_pkg;

	localparam int RING_DEPTH = 8;
	localparam int NUM_LANES = 4;
	localparam int SAMPLE_W = 12;
	localparam int IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int SUM_W = SAMPLE_W + IDX_W;
	localparam int DIV_SHIFT = SUM_W + IDX_W;
	localparam int RECIP_W = DIV_SHIFT + 1;
	localparam int PROD_W = SUM_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'(((64'd1 << DIV_SHIFT) + RING_DEPTH - 1) / RING_DEPTH);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RING_DEPTH - 1);

	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_INTERVAL = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_VOLTAGE_OFFSET = 1'd1;

	localparam logic OP_TICK = 1'b0;
	localparam logic OP_SAMPLES = 1'b1;

	typedef logic [SAMPLE_W-1:0] sample_t;

	typedef struct packed {
		logic    op;
		sample_t battery_raw;
		sample_t current_raw;
		sample_t light_raw;
		sample_t throttle_raw;
	} in_item_t;

	typedef struct packed {
		logic [9:0]  battery_volts_scaled;
		logic [11:0] battery_current_scaled;
		logic [11:0] light_millivolts;
		logic [11:0] throttle_millivolts;
		logic        averaged;
	} out_item_t;

	typedef struct packed {
		logic             load;
		logic             wr;
		logic [IDX_W-1:0] idx;
		logic             acc_clr;
		logic             acc_en;
		logic             div_en;
		logic             use_avg;
	} lane_ctl_t;

endpackage

@@ rtl/core/adc_avg_lane.sv @@
// One channel lane: latest sample, sample ring, sequential sum and divide by depth.
module adc_avg_lane
	import adc_avg_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  lane_ctl_t ctl,
	input  sample_t   sample,
	output sample_t   value
);

	sample_t             latest_q;
	sample_t             ring_q [RING_DEPTH];
	logic [SUM_W-1:0]    acc_q;
	sample_t             avg_q;
	sample_t             latest_next;
	logic [PROD_W-1:0]   prod;

	assign latest_next = ctl.load ? sample : latest_q;
	assign prod = PROD_W'(acc_q) * PROD_W'(RECIP);
	assign value = ctl.use_avg ? avg_q : latest_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latest_q <= '0;
			for (int i = 0; i < RING_DEPTH; i++) begin
				ring_q[i] <= '0;
			end
			acc_q <= '0;
			avg_q <= '0;
		end else begin
			latest_q <= latest_next;
			if (ctl.wr) begin
				ring_q[ctl.idx] <= latest_next;
			end
			if (ctl.acc_clr) begin
				acc_q <= '0;
			end else if (ctl.acc_en) begin
				acc_q <= acc_q + {{(SUM_W-SAMPLE_W){1'b0}}, ring_q[ctl.idx]};
			end
			if (ctl.div_en) begin
				avg_q <= prod[DIV_SHIFT +: SAMPLE_W];
			end
		end
	end

endmodule

@@ rtl/core/adc_avg_merge.sv @@
// Merge stage: scale the four lane values and hold the result transaction.
module adc_avg_merge
	import adc_avg_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     load,
	input  logic                     averaged,
	input  logic [7:0]               offset,
	input  sample_t [NUM_LANES-1:0]  values,
	output logic                     ready,
	output logic                     out_valid,
	input  logic                     out_stall,
	output out_item_t                out_data
);

	logic [20:0] prod_batt;
	logic [23:0] prod_cur;
	logic [23:0] prod_light;
	logic [23:0] prod_thr;
	out_item_t   item;
	logic        valid_q;
	out_item_t   data_q;

	assign prod_batt  = 21'(values[0]) * 21'd330;
	assign prod_cur   = 24'(values[1]) * 24'd3300;
	assign prod_light = 24'(values[2]) * 24'd3300;
	assign prod_thr   = 24'(values[3]) * 24'd3300;

	always_comb begin
		item.battery_volts_scaled   = {1'b0, prod_batt[20:12]} + {2'b00, offset};
		item.battery_current_scaled = prod_cur[23:12];
		item.light_millivolts       = prod_light[23:12];
		item.throttle_millivolts    = prod_thr[23:12];
		item.averaged               = averaged;
	end

	assign ready = !valid_q || !out_stall;
	assign out_valid = valid_q;
	assign out_data = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= item;
		end
	end

endmodule

@@ rtl/core/four_channel_adc_averager_top.sv @@
// Four-channel ADC averager top level: tick counting, acceptance and sequencing.
//
// Input channel (in_valid/in_stall/in_data): each transaction is either a
// millisecond tick (op 0) or a completed conversion with four 12-bit samples
// (op 1). A sample set is taken into the rings once it is pending and the
// tick count exceeds min_interval; that produces exactly one result.
// Output channel (out_valid/out_stall/out_data): scaled battery voltage,
// battery current, light and throttle millivolts, and the averaged flag.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): index 0 writes
// min_interval, index 1 writes voltage_offset; always ready.
// Input stalls: a transaction that yields no result leaves in_stall low. One that
// yields a result holds in_stall high through the scale step, and after warm-up
// also through the per-lane ring sum that reads one entry a cycle and the divide.
// Results appear in out_data in the cycle after the scale step.
// A held result does not block new input; the scale step waits for the
// output register to free while out_stall is high.
// Reset clears the tick count, pending flag, rings and warm-up state.
module four_channel_adc_averager_top
	import adc_avg_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  in_item_t              in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_item_t             out_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SUM,
		ST_DIV,
		ST_SCALE
	} state_t;

	state_t                  state_q;
	logic [15:0]             elapsed_q;
	logic                    pending_q;
	logic [IDX_W-1:0]        widx_q;
	logic                    warm_q;
	logic [IDX_W-1:0]        k_q;
	logic [15:0]             min_interval_q;
	logic [7:0]              voltage_offset_q;

	logic                    take;
	logic [15:0]             elapsed_next;
	logic                    pending_next;
	logic                    fire;
	logic [IDX_W-1:0]        widx_next;
	logic                    warm_next;
	lane_ctl_t               ctl;
	sample_t [NUM_LANES-1:0] samples;
	sample_t [NUM_LANES-1:0] values;
	logic                    merge_ready;
	logic                    merge_load;

	assign in_stall = (state_q != ST_IDLE);
	assign take = in_valid && (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;

	always_comb begin
		if (in_data.op == OP_TICK) begin
			elapsed_next = (elapsed_q != 16'hFFFF) ? elapsed_q + 16'd1 : elapsed_q;
			pending_next = pending_q;
		end else begin
			elapsed_next = elapsed_q;
			pending_next = 1'b1;
		end
		fire = take && pending_next && (elapsed_next > min_interval_q);
		widx_next = (widx_q == LAST_IDX) ? '0 : widx_q + 1'b1;
		warm_next = warm_q || (widx_next == LAST_IDX);
	end

	always_comb begin
		ctl.load    = take && (in_data.op == OP_SAMPLES);
		ctl.wr      = fire;
		ctl.idx     = (state_q == ST_SUM) ? k_q : widx_q;
		ctl.acc_clr = fire;
		ctl.acc_en  = (state_q == ST_SUM);
		ctl.div_en  = (state_q == ST_DIV);
		ctl.use_avg = warm_q;
	end

	assign samples[0] = in_data.battery_raw;
	assign samples[1] = in_data.current_raw;
	assign samples[2] = in_data.light_raw;
	assign samples[3] = in_data.throttle_raw;

	assign merge_load = (state_q == ST_SCALE) && merge_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_interval_q   <= 16'd10;
			voltage_offset_q <= 8'd23;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_MIN_INTERVAL: begin
					min_interval_q <= cfg_data;
				end
				REG_VOLTAGE_OFFSET: begin
					voltage_offset_q <= cfg_data[7:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			elapsed_q <= '0;
			pending_q <= 1'b0;
			widx_q    <= '0;
			warm_q    <= 1'b0;
			k_q       <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (take) begin
						elapsed_q <= fire ? 16'd0 : elapsed_next;
						pending_q <= fire ? 1'b0 : pending_next;
						if (fire) begin
							widx_q  <= widx_next;
							warm_q  <= warm_next;
							k_q     <= '0;
							state_q <= warm_next ? ST_SUM : ST_SCALE;
						end
					end
				end
				ST_SUM: begin
					k_q <= k_q + 1'b1;
					if (k_q == LAST_IDX) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					state_q <= ST_SCALE;
				end
				ST_SCALE: begin
					if (merge_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
		adc_avg_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.sample (samples[g]),
			.value  (values[g])
		);
	end

	adc_avg_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (merge_load),
		.averaged  (warm_q),
		.offset    (voltage_offset_q),
		.values    (values),
		.ready     (merge_ready),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule
